/* rtl/lbtb_pkg.sv */
// ----------------------------------------------------------------------------
// lbtb_pkg: shared types and constants of the binary trie builder
// Node table size, node index type, child pair layout and byte codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbtb_pkg;

	localparam int MAX_NODES = 4096;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int OUT_W     = 12;
	localparam int BYTE_W    = 8;
	localparam int BIT_CNT_W = $clog2(BYTE_W);

	typedef logic [IDX_W-1:0]     node_t;
	typedef logic [OUT_W-1:0]     out_cnt_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

	// Child pointers of one node; zero means no child.
	typedef struct packed {
		node_t one;
		node_t zero;
	} child_pair_t;

	localparam int PAIR_W = $bits(child_pair_t);

	localparam node_t    LAST_NODE = node_t'(MAX_NODES - 1);
	localparam bit_cnt_t LAST_BIT  = bit_cnt_t'(BYTE_W - 1);

	localparam byte_t OPEN_MARK  = 8'h3E;
	localparam byte_t CLOSE_MARK = 8'h0A;
	localparam byte_t SKIP_MARK  = 8'h4E;

	// Low output bits of a node index or depth, zero-extended when narrower.
	function automatic out_cnt_t to_out(input node_t v);
		logic [IDX_W+OUT_W-1:0] ext;
		ext = {{OUT_W{1'b0}}, v};
		return ext[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/lbtb_ram.sv */
// ----------------------------------------------------------------------------
// lbtb_ram: simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbtb_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/lzw_binary_trie_builder_top.sv */
// ----------------------------------------------------------------------------
// lzw_binary_trie_builder_top: binary LZ78 dictionary trie builder
// Skips comments and 'N' bytes, feeds the other bytes bit by bit into a trie.
// ----------------------------------------------------------------------------
// One result per input byte. A skipped or marker byte goes from acceptance
// to S_DONE, which registers its result once the result register is free.
// A byte that enters the trie walks eight bit steps; each step reads the
// current node's child pair from the node table RAM in S_READ (at the root,
// from registers) and evaluates it in S_EVAL, and a step that creates a node
// adds an S_INIT step to initialize the new entry. The root's children
// live in registers and every other entry is written when its node is
// created, so no clearing pass runs after reset. The result register lets
// the next byte be accepted while a result waits to be taken.
`default_nettype none

module lzw_binary_trie_builder_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire lbtb_pkg::byte_t       data_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       byte_used,
	output logic                       in_comment_now,
	output lbtb_pkg::out_cnt_t         node_total,
	output lbtb_pkg::out_cnt_t         walk_depth,
	output logic                       table_overflow
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_INIT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic                   comment_q;
	logic                   used_q;
	logic                   ovf_q;
	lbtb_pkg::node_t        cur_q;
	lbtb_pkg::node_t        depth_q;
	lbtb_pkg::node_t        nodes_q;
	lbtb_pkg::node_t        root_zero_q;
	lbtb_pkg::node_t        root_one_q;
	lbtb_pkg::byte_t        shift_q;
	lbtb_pkg::bit_cnt_t     bit_cnt_q;

	logic [lbtb_pkg::PAIR_W-1:0] rd_data;
	logic [lbtb_pkg::PAIR_W-1:0] wr_data;
	lbtb_pkg::child_pair_t       pair;
	lbtb_pkg::child_pair_t       upd_pair;
	lbtb_pkg::node_t             child;
	lbtb_pkg::node_t             fresh;
	lbtb_pkg::node_t             wr_addr;
	logic                        dir;
	logic                        have_child;
	logic                        full;
	logic                        at_root;
	logic                        wr_en;
	logic                        out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	// Evaluate one bit step against the current node's child pair.
	always_comb begin
		at_root    = (cur_q == '0);
		pair       = at_root ? lbtb_pkg::child_pair_t'({root_one_q, root_zero_q})
		                     : lbtb_pkg::child_pair_t'(rd_data);
		dir        = shift_q[lbtb_pkg::BYTE_W-1];
		child      = dir ? pair.one : pair.zero;
		have_child = (child != '0);
		full       = (nodes_q == lbtb_pkg::LAST_NODE);
		fresh      = nodes_q + 1'b1;
		upd_pair   = pair;
		if (dir) begin
			upd_pair.one = fresh;
		end else begin
			upd_pair.zero = fresh;
		end
	end

	// Link the new child into a non-root parent, then clear the new node's entry.
	always_comb begin
		if (state_q == S_INIT) begin
			wr_en   = 1'b1;
			wr_addr = nodes_q;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == S_EVAL) && !have_child && !full && !at_root;
			wr_addr = cur_q;
			wr_data = upd_pair;
		end
	end

	lbtb_ram #(
		.DEPTH (lbtb_pkg::MAX_NODES),
		.WIDTH (lbtb_pkg::PAIR_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (state_q == S_READ),
		.raddr (cur_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			comment_q      <= 1'b0;
			used_q         <= 1'b0;
			ovf_q          <= 1'b0;
			cur_q          <= '0;
			depth_q        <= '0;
			nodes_q        <= '0;
			root_zero_q    <= '0;
			root_one_q     <= '0;
			shift_q        <= '0;
			bit_cnt_q      <= '0;
			out_valid      <= 1'b0;
			byte_used      <= 1'b0;
			in_comment_now <= 1'b0;
			node_total     <= '0;
			walk_depth     <= '0;
			table_overflow <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (data_byte == lbtb_pkg::OPEN_MARK) begin
							comment_q <= 1'b1;
							used_q    <= 1'b0;
							state_q   <= S_DONE;
						end else if (data_byte == lbtb_pkg::CLOSE_MARK) begin
							comment_q <= 1'b0;
							used_q    <= 1'b0;
							state_q   <= S_DONE;
						end else if (!comment_q && data_byte != lbtb_pkg::SKIP_MARK) begin
							used_q    <= 1'b1;
							shift_q   <= data_byte;
							bit_cnt_q <= '0;
							state_q   <= S_READ;
						end else begin
							used_q  <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (have_child) begin
						cur_q   <= child;
						depth_q <= depth_q + 1'b1;
					end else begin
						cur_q   <= '0;
						depth_q <= '0;
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							nodes_q <= fresh;
							if (at_root) begin
								root_zero_q <= upd_pair.zero;
								root_one_q  <= upd_pair.one;
							end
						end
					end
					if (!have_child && !full) begin
						state_q <= S_INIT;
					end else if (bit_cnt_q == lbtb_pkg::LAST_BIT) begin
						state_q <= S_DONE;
					end else begin
						shift_q   <= shift_q << 1;
						bit_cnt_q <= bit_cnt_q + 1'b1;
						state_q   <= S_READ;
					end
				end
				S_INIT: begin
					if (bit_cnt_q == lbtb_pkg::LAST_BIT) begin
						state_q <= S_DONE;
					end else begin
						shift_q   <= shift_q << 1;
						bit_cnt_q <= bit_cnt_q + 1'b1;
						state_q   <= S_READ;
					end
				end
				S_DONE: begin
					// hold until the result register is free
					if (out_free) begin
						out_valid      <= 1'b1;
						byte_used      <= used_q;
						in_comment_now <= comment_q;
						node_total     <= lbtb_pkg::to_out(nodes_q);
						walk_depth     <= lbtb_pkg::to_out(depth_q);
						table_overflow <= ovf_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
